// File: design/binary_max_heap_queue_unit_assert.svh
// Assertion helpers for the heap queue unit.
`ifndef BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define BMHQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define BMHQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed: next-cycle implication");

`endif

// File: design/bmhq_pkg.sv
package bmhq_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Result handed from the engine to the output register
   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STATUS_W-1:0]       status;
      logic [OCC_W-1:0]          occupancy;
   } result_type;

endpackage

// File: design/bmhq_store.sv
module bmhq_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [AW-1:0]                         wr_addr,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]   wr_data,
   input  logic                                  rd_en,
   input  logic [AW-1:0]                         rd_addr0,
   input  logic [AW-1:0]                         rd_addr1,
   output logic signed [bmhq_pkg::VALUE_W-1:0]   rd_data0,
   output logic signed [bmhq_pkg::VALUE_W-1:0]   rd_data1
);

   logic signed [bmhq_pkg::VALUE_W-1:0] mem_ff [DEPTH];

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read two entries, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0 <= mem_ff[rd_addr0];
         rd_data1 <= mem_ff[rd_addr1];
      end
   end

endmodule

// File: design/bmhq_engine.sv
`include "binary_max_heap_queue_unit_assert.svh"

module bmhq_engine #(
   parameter int CAPACITY = 127,
   parameter int AW       = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]   req_value,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output bmhq_pkg::result_type                  res,
   output logic                                  mem_wr_en,
   output logic [AW-1:0]                         mem_wr_addr,
   output logic signed [bmhq_pkg::VALUE_W-1:0]   mem_wr_data,
   output logic                                  mem_rd_en,
   output logic [AW-1:0]                         mem_rd_addr0,
   output logic [AW-1:0]                         mem_rd_addr1,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]   mem_rd_data0,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]   mem_rd_data1
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_READ,
      S_INS_CMP,
      S_REM_LOAD,
      S_REM_READ,
      S_REM_CMP,
      S_DONE
   } state_type;

   state_type                           state_ff, state_in;
   logic [AW-1:0]                       count_ff, count_in;
   logic [AW-1:0]                       idx_ff, idx_in;
   logic signed [bmhq_pkg::VALUE_W-1:0] item_ff, item_in;
   logic signed [bmhq_pkg::VALUE_W-1:0] top_ff, top_in;
   logic [bmhq_pkg::STATUS_W-1:0]       status_ff, status_in;

   logic [AW:0]                         child;
   logic                                take_right;
   logic signed [bmhq_pkg::VALUE_W-1:0] child_value;
   logic [AW-1:0]                       child_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.removed_value = top_ff;
   assign res.status        = status_ff;
   assign res.occupancy     = bmhq_pkg::OCC_W'(count_ff);

   // Left child index, one bit wider so it can pass the fill count
   assign child = {idx_ff, 1'b0};

   // Pick the larger child; the right one only when it exists and is strictly larger
   assign take_right  = ({1'b0, count_ff} > child) && (mem_rd_data1 > mem_rd_data0);
   assign child_value = take_right ? mem_rd_data1 : mem_rd_data0;
   assign child_idx   = take_right ? (AW'(child) | AW'(1)) : AW'(child);

   // Sequence one operation; reads and writes never share a cycle,
   // so a read always sees the write of the step before it
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      item_in      = item_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = item_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr0 = AW'(1);
      mem_rd_addr1 = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               top_in    = '0;
               status_in = bmhq_pkg::ST_OK;
               if (req_operation == bmhq_pkg::OP_INSERT) begin
                  if (count_ff >= AW'(CAPACITY)) begin
                     status_in = bmhq_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_ff + AW'(1);
                     idx_in   = count_ff + AW'(1);
                     item_in  = req_value;
                     state_in = S_INS_READ;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = bmhq_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     // fetch root and last entry together
                     mem_rd_en = 1'b1;
                     count_in  = count_ff - AW'(1);
                     idx_in    = AW'(1);
                     state_in  = S_REM_LOAD;
                  end
               end
            end
         end
         S_INS_READ: begin
            if (idx_ff == AW'(1)) begin
               mem_wr_en = 1'b1;
               state_in  = S_DONE;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr0 = idx_ff >> 1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (item_ff > mem_rd_data0) begin
               // move parent down, climb one level
               mem_wr_data = mem_rd_data0;
               idx_in      = idx_ff >> 1;
               state_in    = S_INS_READ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_REM_LOAD: begin
            top_in   = mem_rd_data0;
            item_in  = mem_rd_data1;
            state_in = S_REM_READ;
         end
         S_REM_READ: begin
            if (child > {1'b0, count_ff}) begin
               mem_wr_en = 1'b1;
               state_in  = S_DONE;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr0 = AW'(child);
               mem_rd_addr1 = AW'(child) | AW'(1);
               state_in     = S_REM_CMP;
            end
         end
         S_REM_CMP: begin
            mem_wr_en = 1'b1;
            if (item_ff >= child_value) begin
               state_in = S_DONE;
            end else begin
               // move larger child up, descend one level
               mem_wr_data = child_value;
               idx_in      = child_idx;
               state_in    = S_REM_READ;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         item_ff   <= item_in;
         top_ff    <= top_in;
         status_ff <= status_in;
      end
   end

   `BMHQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= AW'(CAPACITY))
   `BMHQ_ASSERT_IMPL(a_rw_split, clock, reset, mem_wr_en, !mem_rd_en)
   `BMHQ_ASSERT_NEXT(a_insert_grows, clock, reset, (state_ff == S_IDLE) && req_valid && (req_operation == bmhq_pkg::OP_INSERT) && (count_ff < AW'(CAPACITY)), count_ff == AW'($past(count_ff) + AW'(1)))
   `BMHQ_ASSERT_IMPL(a_reject_zero, clock, reset, res_valid && (res.status != bmhq_pkg::ST_OK), res.removed_value == '0)

endmodule

// File: design/binary_max_heap_queue_unit.sv
// Max-priority queue of signed 32-bit values held as a binary heap in one
// on-chip memory (CAPACITY+1 words, one write port and two registered read
// ports). Each request either inserts req_value (operation 0) or removes and
// returns the largest value (operation 1); every request yields exactly one
// response with the status (ok, rejected full, rejected empty) and the
// occupancy afterward. One request is worked at a time. An insert moves its
// value up, and a remove the last entry down, by at most floor(log2(CAPACITY))
// heap levels; each level takes one memory read step and one compare-and-write
// step. A rejected request goes straight to its response, and a response
// waits in the engine while the output register is full and not draining.
// The response register lets the next request start while a response still
// waits to be taken. No memory clearing is needed after reset: only values
// from entries already written are ever used.
module binary_max_heap_queue_unit #(
   parameter int CAPACITY = 127
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bmhq_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [bmhq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bmhq_pkg::OCC_W-1:0]            rsp_occupancy
);

   localparam int DEPTH = CAPACITY + 1;
   localparam int AW    = $clog2(DEPTH);

   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic signed [bmhq_pkg::VALUE_W-1:0] wr_data;
   logic                                rd_en;
   logic [AW-1:0]                       rd_addr0;
   logic [AW-1:0]                       rd_addr1;
   logic signed [bmhq_pkg::VALUE_W-1:0] rd_data0;
   logic signed [bmhq_pkg::VALUE_W-1:0] rd_data1;

   logic                                res_valid;
   logic                                res_ready;
   bmhq_pkg::result_type                res;

   logic                                rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::result_type                rsp_ff, rsp_in;

   bmhq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   bmhq_engine #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res),
      .mem_wr_en     (wr_en),
      .mem_wr_addr   (wr_addr),
      .mem_wr_data   (wr_data),
      .mem_rd_en     (rd_en),
      .mem_rd_addr0  (rd_addr0),
      .mem_rd_addr1  (rd_addr1),
      .mem_rd_data0  (rd_data0),
      .mem_rd_data1  (rd_data1)
   );

   // Load the response register when empty or draining
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_ff.removed_value;
   assign rsp_status        = rsp_ff.status;
   assign rsp_occupancy     = rsp_ff.occupancy;

endmodule
